// ----- hdl/cdab_pkg.sv -----
// ----------------------------------------------------------------------------
// cdab_pkg - shared types and constants of the DNS answer builder
// Queue entry layout, terminator and verdict codes, default sizes.
// ----------------------------------------------------------------------------
package cdab_pkg;

	localparam int MAX_PACKET_DEF  = 512;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int HDR_LEN         = 12;
	localparam int ANS_LEN         = 16;

	// what the back end appends after the echo byte of an entry
	typedef enum logic [1:0] {
		TERM_NONE   = 2'd0,
		TERM_ANSWER = 2'd1,
		TERM_DROP   = 2'd2
	} term_t;

	typedef enum logic [1:0] {
		VERD_MORE = 2'd0,
		VERD_DONE = 2'd1,
		VERD_DROP = 2'd2
	} verdict_t;

	typedef struct packed {
		logic       echo_v;
		logic [7:0] echo_byte;
		term_t      term;
	} q_entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

// ----- hdl/cdab_front.sv -----
// ----------------------------------------------------------------------------
// cdab_front - query parser
// Tracks header position and label walk, produces one queue entry per byte that echoes or ends the packet.
// ----------------------------------------------------------------------------
module cdab_front #(
	parameter int MAX_PACKET = cdab_pkg::MAX_PACKET_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  cdab_pkg::q_status_t q_st,
	output logic                q_push,
	output cdab_pkg::q_entry_t  q_entry
);
	import cdab_pkg::*;

	localparam int CNT_W = $clog2(MAX_PACKET + 1);
	localparam int SUM_W = CNT_W + 9;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_NAME   = 4'b0010,
		PH_TAIL   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	logic [CNT_W-1:0] cnt_q, nlp_q, nlp_nx;
	phase_t           phase_q, phase_nx;
	logic [2:0]       tail_q, tail_nx;
	logic             accept, in_range;
	logic             echo_v;
	logic [7:0]       echo_b, hdr_b;
	logic [SUM_W-1:0] label_sum;

	assign in_ready = !q_st.full;
	assign accept   = in_valid && in_ready;
	assign in_range = cnt_q < CNT_W'(MAX_PACKET);

	// header rewrite: ID passes, flags 0x8180, QDCOUNT = ANCOUNT = 1, rest 0
	always_comb begin
		unique case (cnt_q) inside
			CNT_W'(0), CNT_W'(1): hdr_b = in_byte;
			CNT_W'(2):            hdr_b = 8'h81;
			CNT_W'(3):            hdr_b = 8'h80;
			CNT_W'(5), CNT_W'(7): hdr_b = 8'h01;
			default:              hdr_b = 8'h00;
		endcase
	end

	assign label_sum = SUM_W'(cnt_q) + SUM_W'(in_byte) + SUM_W'(1);

	always_comb begin
		phase_nx = phase_q;
		nlp_nx   = nlp_q;
		tail_nx  = tail_q;
		echo_v   = 1'b0;
		echo_b   = in_byte;
		if (in_range) begin
			unique case (phase_q)
				PH_HEADER: begin
					echo_v = 1'b1;
					echo_b = hdr_b;
					if (cnt_q == CNT_W'(HDR_LEN - 1))
						phase_nx = PH_NAME;
				end
				PH_NAME: begin
					echo_v = 1'b1;
					if (cnt_q == nlp_q) begin
						if (in_byte == 8'h00) begin
							phase_nx = PH_TAIL;
							tail_nx  = 3'd4;
						end else if (label_sum > SUM_W'(MAX_PACKET)) begin
							nlp_nx = CNT_W'(MAX_PACKET);
						end else begin
							nlp_nx = label_sum[CNT_W-1:0];
						end
					end
				end
				PH_TAIL: begin
					echo_v = 1'b1;
					if (tail_q != 3'd0)
						tail_nx = tail_q - 3'd1;
					if (tail_nx == 3'd0)
						phase_nx = PH_DONE;
				end
				PH_DONE: ;
				default: ;
			endcase
		end
	end

	always_comb begin
		q_entry.echo_v    = echo_v;
		q_entry.echo_byte = echo_b;
		if (!in_last)
			q_entry.term = TERM_NONE;
		else if (phase_nx == PH_DONE)
			q_entry.term = TERM_ANSWER;
		else
			q_entry.term = TERM_DROP;
	end

	assign q_push = accept && (echo_v || in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			nlp_q   <= CNT_W'(HDR_LEN);
			phase_q <= PH_HEADER;
			tail_q  <= 3'd0;
		end else if (accept) begin
			if (in_last) begin
				cnt_q   <= '0;
				nlp_q   <= CNT_W'(HDR_LEN);
				phase_q <= PH_HEADER;
				tail_q  <= 3'd0;
			end else begin
				if (in_range)
					cnt_q <= cnt_q + CNT_W'(1);
				nlp_q   <= nlp_nx;
				phase_q <= phase_nx;
				tail_q  <= tail_nx;
			end
		end
	end

endmodule

// ----- hdl/cdab_queue.sv -----
// ----------------------------------------------------------------------------
// cdab_queue - short FIFO between parser and answer sequencer
// Register based, head visible combinationally, push and pop in the same cycle.
// ----------------------------------------------------------------------------
module cdab_queue #(
	parameter int DEPTH = cdab_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cdab_pkg::q_entry_t  push_entry,
	input  logic                pop,
	output cdab_pkg::q_entry_t  head,
	output cdab_pkg::q_status_t st
);
	import cdab_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign st.valid = count_q != '0;
	assign st.full  = count_q == CNT_W'(DEPTH);
	assign head     = mem_q[rd_ptr_q];
	assign do_push  = push && !st.full;
	assign do_pop   = pop && st.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- hdl/cdab_back.sv -----
// ----------------------------------------------------------------------------
// cdab_back - response sequencer
// Drains queue entries into the output register, appends A record or drop.
// ----------------------------------------------------------------------------
module cdab_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cdab_pkg::q_status_t q_st,
	input  cdab_pkg::q_entry_t  head,
	output logic                pop,
	input  logic [31:0]         answer_ip,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic [1:0]          verdict
);
	import cdab_pkg::*;

	localparam int IDX_W   = $clog2(ANS_LEN);
	localparam int REC_LEN = ANS_LEN - 4;

	// name pointer to offset 12, type A, class IN, TTL 60, RDLENGTH 4
	localparam logic [7:0] ANS_REC [REC_LEN] = '{
		8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h04
	};

	logic             out_valid_q, out_last_q;
	logic [7:0]       out_byte_q;
	verdict_t         verdict_q;
	logic             echo_sent_q, echo_sent_nx;
	logic [IDX_W-1:0] idx_q, idx_nx;
	logic             load, emit, emit_last;
	logic [7:0]       emit_byte, ans_byte;
	verdict_t         emit_verd;

	assign load = !out_valid_q || out_ready;

	always_comb begin
		if (idx_q < IDX_W'(REC_LEN)) begin
			ans_byte = ANS_REC[idx_q];
		end else begin
			case (idx_q[1:0])
				2'd0:    ans_byte = answer_ip[7:0];
				2'd1:    ans_byte = answer_ip[15:8];
				2'd2:    ans_byte = answer_ip[23:16];
				default: ans_byte = answer_ip[31:24];
			endcase
		end
	end

	always_comb begin
		emit         = 1'b0;
		emit_byte    = 8'h00;
		emit_last    = 1'b0;
		emit_verd    = VERD_MORE;
		pop          = 1'b0;
		echo_sent_nx = echo_sent_q;
		idx_nx       = idx_q;
		if (q_st.valid && load) begin
			emit = 1'b1;
			if (head.echo_v && !echo_sent_q) begin
				emit_byte = head.echo_byte;
				if (head.term == TERM_NONE)
					pop = 1'b1;
				else
					echo_sent_nx = 1'b1;
			end else begin
				unique case (head.term)
					TERM_DROP: begin
						emit_last    = 1'b1;
						emit_verd    = VERD_DROP;
						pop          = 1'b1;
						echo_sent_nx = 1'b0;
					end
					TERM_ANSWER: begin
						emit_byte = ans_byte;
						if (idx_q == IDX_W'(ANS_LEN - 1)) begin
							emit_last    = 1'b1;
							emit_verd    = VERD_DONE;
							pop          = 1'b1;
							echo_sent_nx = 1'b0;
							idx_nx       = '0;
						end else begin
							idx_nx = idx_q + IDX_W'(1);
						end
					end
					default: begin
						emit = 1'b0;
						pop  = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			echo_sent_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load)
				out_valid_q <= emit;
			echo_sent_q <= echo_sent_nx;
			idx_q       <= idx_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			verdict_q  <= emit_verd;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign verdict   = verdict_q;

endmodule

// ----- hdl/captive_dns_answer_builder.sv -----
// ----------------------------------------------------------------------------
// captive_dns_answer_builder - DNS query to captive answer rewriter
// Turns a query datagram into a response pointing every name at one address.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_ready, in_byte, in_last) carries the query one
//  byte per transaction, in_last on the final byte. Output channel
//  (out_valid/out_ready, out_byte, out_last, verdict) carries the response
//  one byte per transaction; verdict is 1 on the closing answer byte and 2
//  on the single drop transaction that replaces the answer for a short or
//  incomplete query. Header and question bytes are echoed (header rewritten),
//  later bytes are swallowed, bytes past MAX_PACKET are not echoed.
//  cfg_we/cfg_wdata load the answer address; write it only while idle.
//  Path: an echoed byte passes through the queue and then the output register.
//  Throughput: one byte per cycle on both sides while the queue is neither
//  full nor empty and the receiver is ready. The final query byte makes the
//  sequencer emit its echo, if any, then the 16-byte A record, and the
//  QUEUE_DEPTH-entry queue absorbs input meanwhile; in_ready is low while full.
//  Receiver stall: the output register holds, the queue fills, and only then
//  is the input side held off.
//  Reset: parse state returns to the header phase, queue and output register
//  empty, answer address 0. No clearing pass.
// ----------------------------------------------------------------------------
module captive_dns_answer_builder #(
	parameter int MAX_PACKET  = cdab_pkg::MAX_PACKET_DEF,
	parameter int QUEUE_DEPTH = cdab_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [1:0]  verdict,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import cdab_pkg::*;

	logic [31:0] answer_ip_q;
	q_status_t   q_st;
	q_entry_t    q_entry, q_head;
	logic        q_push, q_pop;

	// answer address register; the user must write it only between packets, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			answer_ip_q <= 32'd0;
		else if (cfg_we)
			answer_ip_q <= cfg_wdata;
	end

	// parser: one entry per accepted byte that echoes or ends the packet
	cdab_front #(
		.MAX_PACKET(MAX_PACKET)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_st     (q_st),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	// decoupling queue
	cdab_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.head       (q_head),
		.st         (q_st)
	);

	// sequencer with the output register
	cdab_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_st      (q_st),
		.head      (q_head),
		.pop       (q_pop),
		.answer_ip (answer_ip_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.verdict   (verdict)
	);

	// a drop transaction is always a lone zero byte closing the response
	a_drop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == VERD_DROP) |-> (out_byte == 8'h00 && out_last))
		else $error("drop transaction with data or without last");

	// last marker and closing verdict travel together
	a_last_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (verdict != VERD_MORE)))
		else $error("out_last disagrees with verdict");

	// sequencer only pops a filled queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_st.valid)
		else $error("pop from empty queue");

	// every queued entry produces at least one output transaction
	a_push_useful: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_entry.echo_v || q_entry.term != TERM_NONE))
		else $error("empty entry pushed");

endmodule
